FILE: sv/ste_pkg.sv
// Shared types and constants for the sorted table engine.
// No dependencies; used by the controller, the datapath and the top level.
package ste_pkg;

  localparam int OP_W        = 2;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 6;
  localparam int RVAL_W      = 32;
  localparam int CNT_OUT_W   = 7;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic load;    // capture the accepted input word
    logic cmp;     // register the per-cell compare flags and read selection
    logic commit;  // apply the table update and load the result register
  } ste_cmd_t;

endpackage

FILE: sv/ste_ctrl.sv
// Sequencing state machine of the sorted table engine.
// Depends on ste_pkg (command struct); drives the stream handshakes.
module ste_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ste_pkg::ste_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) || ((state_r == S_UPD) && out_free);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.load   = in_tvalid && in_tready;
    cmd.cmp    = (state_r == S_CMP);
    cmd.commit = (state_r == S_UPD) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // a new word may be taken on the same edge as the commit
        if (cmd.commit) state_nxt = cmd.load ? S_CMP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/ste_datapath.sv
// Datapath of the sorted table engine: a row of compare-and-shift cells,
// the entry count and the result register. Depends on ste_pkg.
module ste_datapath #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ste_pkg::ste_cmd_t                     cmd,
  input  logic [ste_pkg::OP_W-1:0]              in_op,
  input  logic signed [ste_pkg::VALUE_W-1:0]    in_value,
  input  logic [ste_pkg::POS_W-1:0]             in_position,
  output logic signed [ste_pkg::RVAL_W-1:0]     out_read_value,
  output logic [ste_pkg::CNT_OUT_W-1:0]         out_entry_count,
  output logic                                  out_is_void,
  output logic [ste_pkg::ST_W-1:0]              out_status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = (CNT_W > ste_pkg::POS_W) ? CNT_W : ste_pkg::POS_W;
  localparam int RD_N  = (CAPACITY < (1 << ste_pkg::POS_W)) ? CAPACITY
                                                            : (1 << ste_pkg::POS_W);

  logic signed [DATA_WIDTH-1:0] ent_r   [CAPACITY];
  logic signed [DATA_WIDTH-1:0] ent_nxt [CAPACITY];
  logic signed [DATA_WIDTH-1:0] ent_up  [CAPACITY];
  logic signed [DATA_WIDTH-1:0] ent_dn  [CAPACITY];

  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [ste_pkg::OP_W-1:0]     op_r;
  logic signed [DATA_WIDTH-1:0] val_r;
  logic [ste_pkg::POS_W-1:0]    pos_r;
  logic [CAPACITY-1:0]          flag_r;
  logic [CAPACITY-1:0]          flag_prev;
  logic signed [DATA_WIDTH-1:0] rd_sel_r;
  logic signed [DATA_WIDTH-1:0] rd_pick;

  logic [PW-1:0]                pos_ext;
  logic                         full;
  logic                         out_of_range;
  logic                         take_v;
  logic signed [ste_pkg::RVAL_W-1:0] rd_nxt;
  logic [ste_pkg::ST_W-1:0]     st_nxt;

  assign pos_ext      = PW'(pos_r);
  assign full         = (count_r >= CNT_W'(CAPACITY));
  assign out_of_range = (pos_ext >= PW'(count_r));
  assign flag_prev    = {flag_r[CAPACITY-2:0], 1'b0};

  // neighbour views for the shift up (insert) and shift down (remove)
  always_comb begin
    ent_up[0]          = val_r;
    ent_dn[CAPACITY-1] = ent_r[CAPACITY-1];
    for (int i = 1; i < CAPACITY; i++) begin
      ent_up[i]   = ent_r[i-1];
      ent_dn[i-1] = ent_r[i];
    end
  end

  always_comb begin
    rd_pick = ent_r[0];
    for (int i = 0; i < RD_N; i++) begin
      if (pos_r == ste_pkg::POS_W'(i)) rd_pick = ent_r[i];
    end
  end

  always_comb begin
    ent_nxt   = ent_r;
    count_nxt = count_r;
    rd_nxt    = '0;
    st_nxt    = ste_pkg::ST_OK;
    take_v    = 1'b0;
    unique case (op_r)
      ste_pkg::OP_INSERT: begin
        if (full) begin
          st_nxt = ste_pkg::ST_FULL;
        end else begin
          // flags form a thermometer: the new value lands at the first set flag,
          // or at the end of the run when none is set
          for (int i = 0; i < CAPACITY; i++) begin
            take_v = (flag_r[i] || (CNT_W'(i) == count_r)) && !flag_prev[i];
            if (take_v) ent_nxt[i] = val_r;
            else if (flag_prev[i]) ent_nxt[i] = ent_up[i];
          end
          count_nxt = count_r + 1'b1;
        end
      end
      ste_pkg::OP_REMOVE: begin
        if (out_of_range) begin
          st_nxt = ste_pkg::ST_RANGE;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (PW'(i) >= pos_ext) ent_nxt[i] = ent_dn[i];
          end
          count_nxt = count_r - 1'b1;
        end
      end
      ste_pkg::OP_READ: begin
        if (out_of_range) begin
          rd_nxt = '1;
          st_nxt = ste_pkg::ST_RANGE;
        end else begin
          rd_nxt = ste_pkg::RVAL_W'(rd_sel_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      val_r <= DATA_WIDTH'(in_value);
      pos_r <= in_position;
    end
    if (cmd.cmp) begin
      for (int i = 0; i < CAPACITY; i++) begin
        flag_r[i] <= (CNT_W'(i) < count_r) && (val_r < ent_r[i]);
      end
      rd_sel_r <= rd_pick;
    end
    if (cmd.commit) begin
      ent_r           <= ent_nxt;
      out_read_value  <= rd_nxt;
      out_entry_count <= ste_pkg::CNT_OUT_W'(count_nxt);
      out_is_void     <= (count_nxt == '0);
      out_status      <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: sv/sorted_table_engine_top.sv
// Sorted table engine, top level: ascending signed table with insert,
// remove and read. An accepted input word passes the compare stage, then
// the shift/commit stage of the cell row, which waits while the result side
// is stalled; a new word can be taken in the same cycle as the commit.
// Reset (rst_n low, synchronous) empties the table, returns the controller
// to idle and drops out_tvalid; entry contents stay undefined until written.
module sorted_table_engine_top #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] value, [37:32] position, [39:38] zero
  input  logic [ste_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] op
  input  logic [ste_pkg::OP_W-1:0]           in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] read_value, [38:32] entry_count, [39] is_void
  output logic [ste_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic [ste_pkg::ST_W-1:0]           out_tuser
);

  ste_pkg::ste_cmd_t                 cmd;
  logic signed [ste_pkg::RVAL_W-1:0] read_value;
  logic [ste_pkg::CNT_OUT_W-1:0]     entry_count;
  logic                              is_void;

  ste_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ste_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_tuser),
    .in_value        (in_tdata[31:0]),
    .in_position     (in_tdata[37:32]),
    .out_read_value  (read_value),
    .out_entry_count (entry_count),
    .out_is_void     (is_void),
    .out_status      (out_tuser)
  );

  assign out_tdata = {is_void, entry_count, read_value};

endmodule
